FILE: hw/rtl/arec_pkg.sv
// shared types, constants and helpers for the adaptive rice escape encoder
// no dependencies; used by every module of the block
package arec_pkg;

  localparam int unsigned MAX_K     = 15;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned K_W       = 4;
  // longest code is 66 bits, plus up to 7 pending bits
  localparam int unsigned WORD_W    = 80;
  localparam int unsigned N1_W      = 5;
  localparam int unsigned NF_W      = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_BYTES = 9;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // one classified item: unary run, terminating zero, binary field
  typedef struct packed {
    logic             flush;
    logic [N1_W-1:0]  n1;
    logic [NF_W-1:0]  nf;
    logic [VAL_W-1:0] field;
    logic [K_W-1:0]   nk;
  } code_req_t;

  function automatic logic [K_W-1:0] sat_k(input logic [5:0] s);
    logic [K_W-1:0] r;
    r = (s > 6'(MAX_K)) ? K_W'(MAX_K) : s[K_W-1:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/arec_front.sv
// front end: zigzag mapping, normal/escape classification and k adaptation
// depends on arec_pkg
module arec_front (
  input  logic                         func,
  input  logic [arec_pkg::VAL_W-1:0]   value,
  input  logic                         is_signed,
  input  logic [arec_pkg::K_W-1:0]     current_k,
  output arec_pkg::code_req_t          req
);

  logic [arec_pkg::K_W-1:0]   k;
  logic [arec_pkg::VAL_W-1:0] u;
  logic [arec_pkg::VAL_W-1:0] p;
  logic                       esc;
  logic [5:0]                 blen;
  logic [4:0]                 g;
  logic [2:0]                 ie;
  logic [2:0]                 lg;
  logic [7:0]                 gi;

  always_comb begin
    k = (current_k > arec_pkg::K_W'(arec_pkg::MAX_K)) ?
        arec_pkg::K_W'(arec_pkg::MAX_K) : current_k;
    u = is_signed ? ({value[arec_pkg::VAL_W-2:0], 1'b0} ^
                     {arec_pkg::VAL_W{value[arec_pkg::VAL_W-1]}}) : value;
    p = u >> k;
    esc = p >= (arec_pkg::VAL_W'(k) + arec_pkg::VAL_W'(8));

    // bit length of u
    blen = '0;
    for (int b = 0; b < arec_pkg::VAL_W; b++) begin
      if (u[b]) blen = 6'(b + 1);
    end

    // escape group count: least i with g*i covering the bit length
    g  = 5'(k) + 5'd5;
    ie = 3'd1;
    for (int j = 1; j < 7; j++) begin
      if ((8'(g) * 8'(j)) < 8'(blen)) ie = ie + 3'd1;
    end
    gi = 8'(g) * 8'(ie);

    // floor(log2 p) for the normal range, p below 23
    lg = '0;
    for (int b = 1; b < 5; b++) begin
      if (p[b]) lg = 3'(b);
    end

    req = '0;
    if (func == arec_pkg::FUNC_FLUSH) begin
      req.flush = 1'b1;
      req.nk    = k;
    end else if (esc) begin
      req.n1    = arec_pkg::N1_W'(k) + arec_pkg::N1_W'(7) + arec_pkg::N1_W'(ie);
      req.nf    = gi[arec_pkg::NF_W-1:0];
      req.field = u;
      req.nk    = arec_pkg::sat_k(6'(k) + 6'({ie, 1'b0}));
    end else begin
      req.n1    = p[arec_pkg::N1_W-1:0];
      req.nf    = arec_pkg::NF_W'(k);
      req.field = u & ((arec_pkg::VAL_W'(1) << k) - arec_pkg::VAL_W'(1));
      if (p == '0) begin
        req.nk = (k == '0) ? k : k - arec_pkg::K_W'(1);
      end else if (p == arec_pkg::VAL_W'(1)) begin
        req.nk = k;
      end else begin
        req.nk = arec_pkg::sat_k(6'(k) + 6'(lg));
      end
    end
  end

endmodule

FILE: hw/rtl/arec_queue.sv
// short queue of classified items between front and back end
// depends on arec_pkg
module arec_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  arec_pkg::code_req_t  wdata,
  output logic                 full,
  input  logic                 pop,
  output arec_pkg::code_req_t  rdata,
  output logic                 not_empty
);

  arec_pkg::code_req_t          mem_r [arec_pkg::Q_DEPTH];
  logic [arec_pkg::Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [arec_pkg::Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [arec_pkg::Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (arec_pkg::Q_PTR_W+1)'(arec_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == arec_pkg::Q_PTR_W'(arec_pkg::Q_DEPTH - 1)) ?
                 '0 : wptr_r + arec_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == arec_pkg::Q_PTR_W'(arec_pkg::Q_DEPTH - 1)) ?
                 '0 : rptr_r + arec_pkg::Q_PTR_W'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + (arec_pkg::Q_PTR_W+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (arec_pkg::Q_PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

endmodule

FILE: hw/rtl/arec_back.sv
// back end: merges codes with pending bits and emits at most one byte per transfer
// depends on arec_pkg
module arec_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  arec_pkg::code_req_t         req,
  input  logic                        req_valid,
  output logic                        req_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic [arec_pkg::K_W-1:0]    out_next_k,
  output logic                        out_last
);

  localparam int unsigned W = arec_pkg::WORD_W;

  logic                          busy_r, busy_nxt;
  logic                          none_r, none_nxt;
  logic [arec_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [arec_pkg::K_W-1:0]      nk_r, nk_nxt;
  logic [W-1:0]                  word_r, word_nxt;
  logic [2:0]                    pc_r, pc_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_bv_r, out_bv_nxt;
  logic [arec_pkg::K_W-1:0]      out_nk_r, out_nk_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_take, emit, emit_last, load;
  logic [W-1:0]                  word_after, ones, fld, code, word_new;
  logic [7:0]                    pend;
  logic [arec_pkg::LEN_W-1:0]    len, total;
  logic [arec_pkg::CNT_W-1:0]    nb;
  logic [2:0]                    rem;

  always_comb begin
    out_take   = !out_valid_r || !out_stall;
    emit       = busy_r && out_take;
    emit_last  = none_r || (cnt_r == arec_pkg::CNT_W'(1));
    word_after = none_r ? word_r : (word_r << 8);
    // pending bits sit left aligned at the top of the word
    pend       = busy_r ? word_after[W-1 -: 8] : word_r[W-1 -: 8];
    load       = req_valid && (!busy_r || (emit && emit_last));

    len   = arec_pkg::LEN_W'(req.n1) + arec_pkg::LEN_W'(1) + arec_pkg::LEN_W'(req.nf);
    ones  = ~({W{1'b1}} >> req.n1);
    fld   = W'(req.field) << (arec_pkg::LEN_W'(W) - len);
    code  = ones | fld;
    total = arec_pkg::LEN_W'(pc_r) + len;
    if (req.flush) begin
      word_new = {pend, {(W-8){1'b0}}};
      nb       = (pc_r != '0) ? arec_pkg::CNT_W'(1) : '0;
      rem      = '0;
    end else begin
      word_new = {pend, {(W-8){1'b0}}} | (code >> pc_r);
      nb       = arec_pkg::CNT_W'(total[arec_pkg::LEN_W-1:3]);
      rem      = total[2:0];
    end
  end

  assign req_pop = load;

  always_comb begin
    busy_nxt = busy_r;
    none_nxt = none_r;
    cnt_nxt  = cnt_r;
    nk_nxt   = nk_r;
    word_nxt = word_r;
    pc_nxt   = pc_r;
    if (emit) begin
      word_nxt = word_after;
      cnt_nxt  = cnt_r - arec_pkg::CNT_W'(1);
      if (emit_last) busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      word_nxt = word_new;
      none_nxt = (nb == '0);
      cnt_nxt  = (nb == '0) ? arec_pkg::CNT_W'(1) : nb;
      nk_nxt   = req.nk;
      pc_nxt   = rem;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_nk_nxt    = out_nk_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = none_r ? 8'd0 : word_r[W-1 -: 8];
      out_bv_nxt    = !none_r;
      out_nk_nxt    = nk_r;
      out_last_nxt  = emit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      none_r      <= 1'b0;
      cnt_r       <= '0;
      word_r      <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      none_r      <= none_nxt;
      cnt_r       <= cnt_nxt;
      word_r      <= word_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nk_r       <= nk_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_nk_r   <= out_nk_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_next_k     = out_nk_r;
  assign out_last       = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0 && cnt_r <= arec_pkg::CNT_W'(arec_pkg::MAX_BYTES)))
    else $error("byte count out of range");

  a_idle_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (word_r[W-9:0] == '0))
    else $error("stray bits below pending byte");

  a_pend_padded: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (8'(word_r[W-1 -: 8] << pc_r) == 8'd0))
    else $error("pending bits beyond pending count");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bv_r) |-> out_last_r)
    else $error("byteless result not marked last");

endmodule

FILE: hw/rtl/adaptive_rice_escape_encoder_core.sv
// top level of the adaptive rice escape encoder
// depends on arec_pkg, arec_front, arec_queue, arec_back
//
// Adaptive Rice/escape encoder packing codes MSB first into bytes. Each
// encode item yields its completed bytes (0 to 9) with the adapted k on
// every result; an item that completes no byte yields a single result with
// byte_valid low. A flush pads pending bits with zeros to one byte. The
// front end classifies an item in its accept cycle and writes a two-entry
// queue; the back end merges the code with the pending bits into its word
// register and then emits one result per cycle into the output register
// while the output is not stalled. That one-byte-per-cycle output is what
// sets the sustained rate; an item passes the queue, the word register and
// the output register on its way from accept to first result.
module adaptive_rice_escape_encoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [arec_pkg::VAL_W-1:0]   in_value,
  input  logic                         in_is_signed,
  input  logic [arec_pkg::K_W-1:0]     in_current_k,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_byte_valid,
  output logic [arec_pkg::K_W-1:0]     out_next_k,
  output logic                         out_last
);

  arec_pkg::code_req_t front_req, q_rdata;
  logic                q_full, q_not_empty, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  arec_front u_front (
    .func      (in_func),
    .value     (in_value),
    .is_signed (in_is_signed),
    .current_k (in_current_k),
    .req       (front_req)
  );

  arec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  arec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (q_rdata),
    .req_valid      (q_not_empty),
    .req_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_next_k     (out_next_k),
    .out_last       (out_last)
  );

endmodule

FILE: dv/arec_checker.sv
// checker for the adaptive rice escape encoder: predicts the byte stream and k updates
// from every input transfer and compares each result transfer in order
// depends on arec_pkg
module arec_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_func,
  input  logic [arec_pkg::VAL_W-1:0] in_value,
  input  logic                       in_is_signed,
  input  logic [arec_pkg::K_W-1:0]   in_current_k,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [7:0]                 out_byte,
  input  logic                       out_byte_valid,
  input  logic [arec_pkg::K_W-1:0]   out_next_k,
  input  logic                       out_last,
  output int                         errors,
  output int                         exp_left,
  output int                         n_bytes,
  output int                         n_escapes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]               data;
    logic                     has_data;
    logic [arec_pkg::K_W-1:0] k_next;
    logic                     is_last;
  } stream_res_t;

  stream_res_t stream_q[$];
  logic [7:0]  done_bytes[$];
  logic [7:0]  pend_bits;
  int unsigned pend_cnt;

  initial begin
    errors    = 0;
    exp_left  = 0;
    n_bytes   = 0;
    n_escapes = 0;
    pend_bits = '0;
    pend_cnt  = 0;
  end

  function automatic void pack_bit(logic b);
    pend_bits = {pend_bits[6:0], b};
    pend_cnt++;
    if (pend_cnt == 8) begin
      done_bytes.push_back(pend_bits);
      pend_bits = '0;
      pend_cnt  = 0;
    end
  endfunction

  function automatic void code_item(logic f, logic [arec_pkg::VAL_W-1:0] v, logic sgn,
                                    logic [arec_pkg::K_W-1:0] k_in);
    logic [arec_pkg::VAL_W-1:0] u;
    logic [arec_pkg::VAL_W-1:0] p;
    logic [63:0]                rest;
    logic [63:0]                fld;
    int unsigned                k;
    int unsigned                nk;
    int unsigned                g;
    int unsigned                grp;
    int unsigned                rise;
    int unsigned                n_ones;
    int unsigned                n_field;
    stream_res_t                r;
    k = (k_in > arec_pkg::MAX_K) ? arec_pkg::MAX_K : k_in;
    nk = k;
    done_bytes.delete();
    if (f == arec_pkg::FUNC_FLUSH) begin
      if (pend_cnt != 0) begin
        done_bytes.push_back(pend_bits << (8 - pend_cnt));
        pend_bits = '0;
        pend_cnt  = 0;
      end
    end else begin
      u = sgn ? ((v << 1) ^ {arec_pkg::VAL_W{v[arec_pkg::VAL_W-1]}}) : v;
      p = u >> k;
      if (p >= 8 + k) begin
        // escape: groups of 5+k bits, as many as the value needs
        g    = 5 + k;
        grp  = 1;
        rest = {32'd0, u};
        while (rest >= (64'd1 << g)) begin
          rest = rest >> g;
          grp++;
        end
        n_ones  = 7 + k + grp;
        n_field = g * grp;
        fld     = {32'd0, u};
        nk      = (k + 2 * grp > arec_pkg::MAX_K) ? arec_pkg::MAX_K : k + 2 * grp;
        n_escapes++;
      end else begin
        n_ones  = p;
        n_field = k;
        fld     = {32'd0, u} & ((64'd1 << k) - 64'd1);
        if (p == 0) begin
          nk = (k > 0) ? k - 1 : 0;
        end else if (p > 1) begin
          rise = $clog2(p + 1) - 1;
          nk = (k + rise > arec_pkg::MAX_K) ? arec_pkg::MAX_K : k + rise;
        end
      end
      repeat (n_ones) pack_bit(1'b1);
      pack_bit(1'b0);
      for (int b = int'(n_field) - 1; b >= 0; b--) pack_bit(fld[b]);
    end
    if (done_bytes.size() == 0) begin
      r = '{data: 8'h00, has_data: 1'b0, k_next: arec_pkg::K_W'(nk), is_last: 1'b1};
      stream_q.push_back(r);
    end else begin
      foreach (done_bytes[i]) begin
        r = '{data: done_bytes[i], has_data: 1'b1, k_next: arec_pkg::K_W'(nk),
              is_last: (i == done_bytes.size() - 1)};
        stream_q.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    stream_res_t want;
    if (!rst_n) begin
      stream_q.delete();
      pend_bits = '0;
      pend_cnt  = 0;
    end else begin
      // results are checked before the new input transfer is predicted
      if (out_valid && !out_stall) begin
        if (stream_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result byte=%02h bv=%0b k=%0d last=%0b",
                     $realtime, out_byte, out_byte_valid, out_next_k, out_last);
        end else begin
          want = stream_q.pop_front();
          if (want.has_data) n_bytes++;
          if (out_byte !== want.data || out_byte_valid !== want.has_data ||
              out_next_k !== want.k_next || out_last !== want.is_last) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp byte=%02h bv=%0b k=%0d last=%0b,",
                        " got byte=%02h bv=%0b k=%0d last=%0b"},
                       $realtime, want.data, want.has_data, want.k_next, want.is_last,
                       out_byte, out_byte_valid, out_next_k, out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        code_item(in_func, in_value, in_is_signed, in_current_k);
    end
    exp_left = stream_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// top of the adaptive rice escape encoder testbench: clock, reset, stimulus and verdict
// depends on arec_pkg, arec_checker and adaptive_rice_escape_encoder_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_func      = arec_pkg::FUNC_ENCODE;
  logic [arec_pkg::VAL_W-1:0] in_value     = '0;
  logic                       in_is_signed = 1'b0;
  logic [arec_pkg::K_W-1:0]   in_current_k = '0;
  logic                       out_stall    = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic                       out_byte_valid;
  logic [arec_pkg::K_W-1:0]   out_next_k;
  logic                       out_last;

  int          errors;
  int          exp_left;
  int          n_bytes;
  int          n_escapes;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          n_items   = 0;
  int          n_flush   = 0;

  adaptive_rice_escape_encoder_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_is_signed   (in_is_signed),
    .in_current_k   (in_current_k),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_next_k     (out_next_k),
    .out_last       (out_last)
  );

  arec_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_is_signed   (in_is_signed),
    .in_current_k   (in_current_k),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_next_k     (out_next_k),
    .out_last       (out_last),
    .errors         (errors),
    .exp_left       (exp_left),
    .n_bytes        (n_bytes),
    .n_escapes      (n_escapes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(input logic f, input logic [arec_pkg::VAL_W-1:0] v, input logic s,
                      input logic [arec_pkg::K_W-1:0] k);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_value     <= v;
    in_is_signed <= s;
    in_current_k <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (f == arec_pkg::FUNC_FLUSH) n_flush++;
    @(negedge clk);
  endtask

  task automatic rand_item();
    logic                       f;
    logic                       s;
    logic [arec_pkg::VAL_W-1:0] v;
    logic [arec_pkg::K_W-1:0]   k;
    int unsigned                sel;
    int unsigned                p;
    k   = arec_pkg::K_W'($urandom_range(0, 15));
    s   = 1'($urandom_range(0, 1));
    f   = ($urandom_range(99) < 8) ? arec_pkg::FUNC_FLUSH : arec_pkg::FUNC_ENCODE;
    sel = $urandom_range(99);
    if (sel < 55) begin
      // quotient near the escape threshold for this k
      p = $urandom_range(0, 10 + k);
      v = (arec_pkg::VAL_W'(p) << k) | ($urandom & ((32'd1 << k) - 32'd1));
      // undo the zigzag so the coded value keeps the chosen quotient
      if (s) v = {1'b0, v[arec_pkg::VAL_W-1:1]} ^ {arec_pkg::VAL_W{v[0]}};
    end else if (sel < 80) begin
      v = $urandom >> $urandom_range(0, 31);
    end else begin
      v = $urandom;
    end
    send(f, v, s, k);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (exp_left != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(arec_pkg::FUNC_FLUSH,  32'h0, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'd0, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'd1, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'd2, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'd7, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'd8, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'hFFFF_FFFF, 1'b0, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'hFFFF_FFFF, 1'b1, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'h8000_0000, 1'b1, 4'd0);
    send(arec_pkg::FUNC_ENCODE, 32'h7FFF_FFFF, 1'b1, 4'd15);
    send(arec_pkg::FUNC_ENCODE, 32'hFFFF_FFFF, 1'b0, 4'd15);
    send(arec_pkg::FUNC_ENCODE, 32'd0, 1'b0, 4'd15);
    send(arec_pkg::FUNC_ENCODE, (32'd22 << 15) | 32'h7FFF, 1'b0, 4'd15);
    send(arec_pkg::FUNC_ENCODE, 32'd23 << 15, 1'b0, 4'd15);
    send(arec_pkg::FUNC_ENCODE, 32'd7 << 3, 1'b0, 4'd3);
    send(arec_pkg::FUNC_ENCODE, 32'd11 << 3, 1'b0, 4'd3);
    send(arec_pkg::FUNC_ENCODE, (32'd10 << 3) | 32'd7, 1'b0, 4'd3);
    send(arec_pkg::FUNC_FLUSH,  32'hFFFF_FFFF, 1'b1, 4'd9);
    send(arec_pkg::FUNC_FLUSH,  32'h0, 1'b0, 4'd15);
    send(arec_pkg::FUNC_ENCODE, 32'h5555_5555, 1'b1, 4'd8);
    send(arec_pkg::FUNC_ENCODE, 32'hAAAA_AAAA, 1'b1, 4'd8);
    send(arec_pkg::FUNC_ENCODE, 32'd1, 1'b1, 4'd1);
    send(arec_pkg::FUNC_FLUSH,  32'h0, 1'b0, 4'd4);
    // sender holds off until every expected result has come back
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (97) rand_item();
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;

    while (exp_left != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d items (%0d flushes, %0d escape codes) over four handshake phases,",
             n_items, n_flush, n_escapes);
    $display("checked %0d stream bytes against the predicted bit packing", n_bytes);
    if (errors == 0 && exp_left == 0) begin
      $display("adaptive_rice_escape_encoder_core regression: pass");
    end else begin
      $display("adaptive_rice_escape_encoder_core regression: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", exp_left);
    $display("adaptive_rice_escape_encoder_core regression: fail");
    $finish;
  end

endmodule
